// ===== src/lcd_mode_line_timing_unit_defines.svh =====
// Assertion macros for the LCD mode and line timing unit.
// Included by the top level; no other dependencies.
`ifndef LCD_MODE_LINE_TIMING_UNIT_DEFINES_SVH
`define LCD_MODE_LINE_TIMING_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// property that must hold at every edge outside reset
`define LMLT_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
// same-cycle implication
`define LMLT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define LMLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define LMLT_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define LMLT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LMLT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/lmlt_pkg.sv =====
// Package for the LCD mode and line timing unit: word types, state type, constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lmlt_pkg;

	localparam int unsigned TICK_W  = 6;
	localparam int unsigned CYCLE_W = 7;   // count stays below 114
	localparam int unsigned LINE_W  = 8;

	localparam logic [LINE_W-1:0]  LINE_CYCLES = 8'd114;
	localparam logic [LINE_W-1:0]  VBLANK_LINE = 8'd144;
	localparam logic [LINE_W-1:0]  LAST_LINE   = 8'd153;
	localparam logic [CYCLE_W-1:0] OAM_END     = 7'd20;
	localparam logic [CYCLE_W-1:0] XFER_END    = 7'd63;

	// STAT enable bit positions
	localparam logic [1:0] EN_HBLANK = 2'd0;
	localparam logic [1:0] EN_VBLANK = 2'd1;
	localparam logic [1:0] EN_OAM    = 2'd2;
	localparam logic [1:0] EN_COINC  = 2'd3;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_XFER   = 2'd3
	} lmlt_mode_t;

	typedef struct packed {
		logic [TICK_W-1:0] tick_cycles;
		logic              lcd_on;
		logic [3:0]        stat_enables;
		logic [7:0]        compare_line;
	} lmlt_in_t;

	typedef struct packed {
		logic [LINE_W-1:0] current_line;
		lmlt_mode_t        lcd_mode;
		logic              coincidence_flag;
		logic              stat_irq;
		logic              vblank_irq;
		logic              line_done;
	} lmlt_out_t;

	typedef struct packed {
		logic [CYCLE_W-1:0] cycle;
		logic [LINE_W-1:0]  line;
		logic               irq_sig;
		logic               match;
	} lmlt_state_t;

endpackage
`default_nettype wire

// ===== src/lmlt_ifs.sv =====
// Valid/ready channel interfaces for tick words and result words.
// Depends on lmlt_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface lmlt_in_if
	import lmlt_pkg::*;
	;
	logic     valid;
	logic     ready;
	lmlt_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lmlt_out_if
	import lmlt_pkg::*;
	;
	logic      valid;
	logic      ready;
	lmlt_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/lcd_mode_line_timing_unit.sv =====
// Top level of the LCD mode and line timing unit: input stage, state, result stage.
// Depends on lmlt_pkg, lmlt_ifs, lmlt_core and the assertion macro header.
//
//   channel  dir  word        contents
//   tick     in   lmlt_in_t   tick_cycles, lcd_on, stat_enables, compare_line
//   result   out  lmlt_out_t  current_line, lcd_mode, coincidence_flag, irqs, line_done
//
// One tick word per clock while the result is not stalled: accept into the input stage,
// then one pass through lmlt_core updates the line/count state and loads the
// result register, so back-to-back words see each other's state with no bubble.
// arst_n clears both stage valids and all timing state (line 0, count 0).
// A stalled result holds the input stage; the input stage still takes a word
// whenever it is empty or moving on in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "lcd_mode_line_timing_unit_defines.svh"
module lcd_mode_line_timing_unit
	import lmlt_pkg::*;
(
	input  wire            clk,
	input  wire            arst_n,
	lmlt_in_if.sink        tick,
	lmlt_out_if.source     result
);

	// input stage
	logic        valid_s1;
	lmlt_in_t    item_s1;
	// result stage
	logic        valid_s2;
	lmlt_out_t   res_s2;
	// timing state (count, line, STAT signal, held coincidence)
	lmlt_state_t state_q;

	lmlt_state_t state_nxt;
	lmlt_out_t   res_nxt;
	logic        advance;

	// word in stage 1 moves on when the result slot is free or being drained
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign tick.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			item_s1 <= tick.data;
		end
	end

	lmlt_core u_core (
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// state only moves when a word actually goes through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				state_q  <= state_nxt;
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign result.valid = valid_s2;
	assign result.data  = res_s2;

	// line never leaves 0..153, count never reaches a full line
	`LMLT_ASSERT_ALWAYS(a_line_range, clk, arst_n, state_q.line <= LAST_LINE)
	`LMLT_ASSERT_ALWAYS(a_cycle_range, clk, arst_n, LINE_W'(state_q.cycle) < LINE_CYCLES)
	// vblank request only on the entry into line 144
	`LMLT_ASSERT_IMP(a_vbl_line, clk, arst_n, valid_s2 && res_s2.vblank_irq,
		res_s2.current_line == VBLANK_LINE)
	// display off clears the counters
	`LMLT_ASSERT_NEXT(a_off_clears, clk, arst_n, advance && !item_s1.lcd_on,
		state_q.line == '0 && state_q.cycle == '0)

endmodule
`default_nettype wire

// ===== src/lmlt_core.sv =====
// Per-tick mode, STAT signal and line counter update (combinational).
// Depends on lmlt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lmlt_core
	import lmlt_pkg::*;
(
	input  var lmlt_in_t    item,
	input  var lmlt_state_t cur,
	output lmlt_state_t     nxt,
	output lmlt_out_t       res
);

	logic [LINE_W-1:0] sum;
	logic [LINE_W-1:0] line_inc;
	logic              sig_a;
	logic              matched;
	lmlt_mode_t        mode_a;

	assign sum      = {1'b0, cur.cycle} + {2'b00, item.tick_cycles};
	assign line_inc = LINE_W'(cur.line + 8'd1);
	assign matched  = (item.compare_line == cur.line) ||
		(item.compare_line == 8'd0 && cur.line == LAST_LINE);

	// mode and signal from the state before the tick
	always_comb begin
		priority if (cur.line >= VBLANK_LINE) begin
			mode_a = MODE_VBLANK;
			sig_a  = item.stat_enables[EN_VBLANK];
		end else if (cur.cycle <= OAM_END) begin
			mode_a = MODE_OAM;
			sig_a  = item.stat_enables[EN_OAM];
		end else if (cur.cycle <= XFER_END) begin
			mode_a = MODE_XFER;
			sig_a  = cur.irq_sig;
		end else begin
			mode_a = MODE_HBLANK;
			sig_a  = item.stat_enables[EN_HBLANK];
		end
	end

	always_comb begin
		logic sig1;
		sig1 = sig_a | (matched & item.stat_enables[EN_COINC]);
		nxt  = cur;
		res  = '0;
		if (!item.lcd_on) begin
			nxt.cycle            = '0;
			nxt.line             = '0;
			res.lcd_mode         = MODE_HBLANK;
			res.coincidence_flag = cur.match;
		end else begin
			nxt.match            = matched;
			nxt.irq_sig          = sig1;
			res.coincidence_flag = matched;
			res.stat_irq         = !cur.irq_sig && sig1;
			res.lcd_mode         = mode_a;
			nxt.cycle            = sum[CYCLE_W-1:0];
			if (sum >= LINE_CYCLES) begin
				res.line_done = cur.line < VBLANK_LINE;
				nxt.cycle     = CYCLE_W'(sum - LINE_CYCLES);
				nxt.line      = line_inc;
				if (line_inc == VBLANK_LINE) begin
					res.vblank_irq = 1'b1;
					if (item.stat_enables[EN_OAM]) begin
						res.stat_irq = res.stat_irq | !sig1;
						nxt.irq_sig  = 1'b1;
					end
				end else if (line_inc > LAST_LINE) begin
					nxt.line     = '0;
					res.lcd_mode = MODE_OAM;
				end
			end
			res.current_line = nxt.line;
		end
	end

endmodule
`default_nettype wire
